@@ design/cbps_pkg.sv @@
// Shared types, constants and fixed-point helpers for the circle body physics step unit.
`default_nettype none
package cbps_pkg;

	localparam int MAX_BODIES = 16;
	localparam int IDX_W      = $clog2(MAX_BODIES);
	localparam int CNT_W      = $clog2(MAX_BODIES + 1);
	localparam int RAD_W      = 30;
	localparam int BODY_W     = 4 * 32 + RAD_W;
	localparam int FORCE_W    = 2 * 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_W      = 31;

	localparam logic [CFG_IDX_W-1:0] REG_DRAG   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ASPECT = 2'd1;

	localparam logic [CFG_W-1:0] ASPECT_RESET = 31'd65536;

	typedef struct packed {
		logic               action;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic [30:0]        scale_x;
		logic [30:0]        scale_y;
		logic [30:0]        time_step;
	} in_word_t;

	typedef struct packed {
		logic [5:0]         body_index;
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic               last_body;
	} out_word_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_ROW_RD, ST_ROW_LD, ST_PAIR_RD, ST_PAIR_LD, ST_DIFF, ST_SQ_X, ST_SQ_Y,
		ST_SQ_SUM, ST_SQRT, ST_LEN, ST_DIV, ST_UNIT, ST_MUL_X, ST_MUL_Y, ST_FY, ST_APPLY,
		ST_NEXT, ST_ROW_WB, ST_MV_RD, ST_MV_LD, ST_WALL, ST_DRAG_X, ST_DRAG_Y, ST_VEL_X,
		ST_VEL_Y, ST_POS_X, ST_POS_Y, ST_POS_FIN, ST_EMIT
	} state_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_START, OP_ROW_LD, OP_PAIR_LD, OP_DIFF, OP_SQ_X, OP_SQ_Y,
		OP_SQ_SUM, OP_SQRT, OP_LEN, OP_DIV, OP_UNIT, OP_MUL_X, OP_MUL_Y, OP_FY, OP_APPLY,
		OP_ROW_WB, OP_MV_LD, OP_WALL, OP_DRAG_X, OP_DRAG_Y, OP_VEL_X, OP_VEL_Y, OP_POS_X,
		OP_POS_Y, OP_POS_FIN, OP_EMIT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] addr;
		logic             load_we;
		logic             last;
	} ctl_cmd_t;

	typedef struct packed {
		logic far;
		logic len_bad;
		logic sqrt_last;
		logic div_last;
		logic out_free;
	} dp_status_t;

	function automatic logic signed [65:0] ext32(input logic signed [31:0] v);
		return {{34{v[31]}}, v};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -66'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// divide by 2^16, rounding toward zero
	function automatic logic signed [65:0] trunc16(input logic signed [65:0] v);
		logic signed [65:0] r;
		r = v + (v[65] ? 66'sd65535 : 66'sd0);
		return r >>> 16;
	endfunction

	function automatic logic signed [65:0] mul1000(input logic signed [65:0] v);
		return (v <<< 10) - (v <<< 4) - (v <<< 3);
	endfunction

endpackage
`default_nettype wire

@@ design/cbps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cbps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ design/cbps_ctrl.sv @@
// Sequencer: walks loads, body pairs, per-body moves and result words.
`default_nettype none
module cbps_ctrl import cbps_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_action,
	output logic            in_ready,
	input  wire dp_status_t status,
	output ctl_cmd_t        cmd
);
	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, i_q, j_q, i_inc, j_inc;

	assign i_inc = i_q + CNT_W'(1);
	assign j_inc = j_q + CNT_W'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_action && count_q != '0)
					state_d = ST_ROW_RD;
			end
			ST_ROW_RD:  state_d = ST_ROW_LD;
			ST_ROW_LD:  state_d = (i_inc < count_q) ? ST_PAIR_RD : ST_ROW_WB;
			ST_PAIR_RD: state_d = ST_PAIR_LD;
			ST_PAIR_LD: state_d = ST_DIFF;
			ST_DIFF:    state_d = ST_SQ_X;
			ST_SQ_X:    state_d = status.far ? ST_NEXT : ST_SQ_Y;
			ST_SQ_Y:    state_d = ST_SQ_SUM;
			ST_SQ_SUM:  state_d = ST_SQRT;
			ST_SQRT:    state_d = status.sqrt_last ? ST_LEN : ST_SQRT;
			ST_LEN:     state_d = status.len_bad ? ST_NEXT : ST_DIV;
			ST_DIV:     state_d = status.div_last ? ST_UNIT : ST_DIV;
			ST_UNIT:    state_d = ST_MUL_X;
			ST_MUL_X:   state_d = ST_MUL_Y;
			ST_MUL_Y:   state_d = ST_FY;
			ST_FY:      state_d = ST_APPLY;
			ST_APPLY:   state_d = ST_NEXT;
			ST_NEXT:    state_d = (j_inc < count_q) ? ST_PAIR_RD : ST_ROW_WB;
			ST_ROW_WB:  state_d = (i_inc < count_q) ? ST_ROW_RD : ST_MV_RD;
			ST_MV_RD:   state_d = ST_MV_LD;
			ST_MV_LD:   state_d = ST_WALL;
			ST_WALL:    state_d = ST_DRAG_X;
			ST_DRAG_X:  state_d = ST_DRAG_Y;
			ST_DRAG_Y:  state_d = ST_VEL_X;
			ST_VEL_X:   state_d = ST_VEL_Y;
			ST_VEL_Y:   state_d = ST_POS_X;
			ST_POS_X:   state_d = ST_POS_Y;
			ST_POS_Y:   state_d = ST_POS_FIN;
			ST_POS_FIN: state_d = ST_EMIT;
			ST_EMIT: begin
				if (status.out_free)
					state_d = (i_inc < count_q) ? ST_MV_RD : ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		cmd.op      = OP_NOP;
		cmd.addr    = i_q[IDX_W-1:0];
		cmd.load_we = 1'b0;
		cmd.last    = (i_inc == count_q);
		case (state_q)
			ST_IDLE: begin
				cmd.addr = count_q[IDX_W-1:0];
				if (in_valid && !in_action) begin
					cmd.op      = OP_LOAD;
					cmd.load_we = (count_q < CNT_W'(MAX_BODIES));
				end else if (in_valid && in_action) begin
					cmd.op = OP_START;
				end
			end
			ST_ROW_LD:  cmd.op = OP_ROW_LD;
			ST_PAIR_RD: cmd.addr = j_q[IDX_W-1:0];
			ST_PAIR_LD: begin
				cmd.op   = OP_PAIR_LD;
				cmd.addr = j_q[IDX_W-1:0];
			end
			ST_DIFF:    cmd.op = OP_DIFF;
			ST_SQ_X:    cmd.op = OP_SQ_X;
			ST_SQ_Y:    cmd.op = OP_SQ_Y;
			ST_SQ_SUM:  cmd.op = OP_SQ_SUM;
			ST_SQRT:    cmd.op = OP_SQRT;
			ST_LEN:     cmd.op = OP_LEN;
			ST_DIV:     cmd.op = OP_DIV;
			ST_UNIT:    cmd.op = OP_UNIT;
			ST_MUL_X:   cmd.op = OP_MUL_X;
			ST_MUL_Y:   cmd.op = OP_MUL_Y;
			ST_FY:      cmd.op = OP_FY;
			ST_APPLY: begin
				cmd.op   = OP_APPLY;
				cmd.addr = j_q[IDX_W-1:0];
			end
			ST_ROW_WB:  cmd.op = OP_ROW_WB;
			ST_MV_LD:   cmd.op = OP_MV_LD;
			ST_WALL:    cmd.op = OP_WALL;
			ST_DRAG_X:  cmd.op = OP_DRAG_X;
			ST_DRAG_Y:  cmd.op = OP_DRAG_Y;
			ST_VEL_X:   cmd.op = OP_VEL_X;
			ST_VEL_Y:   cmd.op = OP_VEL_Y;
			ST_POS_X:   cmd.op = OP_POS_X;
			ST_POS_Y:   cmd.op = OP_POS_Y;
			ST_POS_FIN: cmd.op = OP_POS_FIN;
			ST_EMIT:    cmd.op = OP_EMIT;
			default:    cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_action && count_q < CNT_W'(MAX_BODIES))
						count_q <= count_q + CNT_W'(1);
					i_q <= '0;
				end
				ST_ROW_LD: j_q <= i_inc;
				ST_NEXT:   j_q <= j_inc;
				ST_ROW_WB: i_q <= (i_inc < count_q) ? i_inc : '0;
				ST_EMIT: begin
					if (status.out_free) begin
						if (i_inc < count_q)
							i_q <= i_inc;
						else
							count_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BODIES))
		else $error("body count above capacity");
	a_step_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && in_action && count_q != '0) |=>
		state_q == ST_ROW_RD)
		else $error("step did not start the pair walk");
	a_i_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (i_q < count_q))
		else $error("body index outside loaded set");
	a_j_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAIR_RD) |-> (j_q > i_q && j_q < count_q))
		else $error("pair index out of order");
	a_store_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && status.out_free && i_inc == count_q) |=> count_q == '0)
		else $error("store not emptied after last word");
endmodule
`default_nettype wire

@@ design/cbps_dp.sv @@
// Datapath: body and force stores, multiplier, square root and divider, output word.
`default_nettype none
module cbps_dp import cbps_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ctl_cmd_t         cmd,
	input  wire in_word_t         in_data,
	input  wire logic [CFG_W-1:0] drag,
	input  wire logic [CFG_W-1:0] inv_aspect,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output out_word_t             out_data,
	output dp_status_t            status
);
	logic                body_we, force_we;
	logic [BODY_W-1:0]   body_wdata, body_rdata;
	logic [FORCE_W-1:0]  force_wdata, force_rdata;
	logic [IDX_W-1:0]    force_waddr;
	logic [MAX_BODIES-1:0] fvalid_q;
	logic signed [31:0]  rd_px, rd_py, rd_vx, rd_vy, rd_fx, rd_fy;
	logic [RAD_W-1:0]    rd_r;
	logic [31:0]         rad_sum;

	logic signed [31:0]  px_a_q, py_a_q, vx_a_q, vy_a_q, px_b_q, py_b_q;
	logic [RAD_W-1:0]    r_a_q, r_b_q;
	logic signed [31:0]  acc_x_q, acc_y_q, fb_x_q, fb_y_q, fx_q, fy_q;
	logic signed [31:0]  nvx_q, nvy_q, npx_q, npy_q;
	logic [30:0]         ds_q;
	logic signed [32:0]  dx_q, dy_q, dx_d, dy_d, ov_q;
	logic [32:0]         adx_q, ady_q;
	logic [RAD_W:0]      s_q;
	logic signed [32:0]  ma, mb;
	logic signed [65:0]  p_q, fcalc, ptr;
	logic [61:0]         sq_q;
	logic [63:0]         rad_q, root_q, bit_q, rsum;
	logic [31:0]         len_q;
	logic [32:0]         remx_q, remy_q, rsx, rsy;
	logic                gex, gey;
	logic [16:0]         qx_q, qy_q;
	logic signed [17:0]  ux_q, uy_q;
	logic [4:0]          it_q;
	logic signed [35:0]  r36, px36, py36, ia36, left, right, top, bot, wx, wy;
	logic signed [47:0]  wx48, wy48, wx_q, wy_q;
	logic                out_valid_q, out_free;
	out_word_t           out_q;

	assign rad_sum = {1'b0, in_data.scale_x} + {1'b0, in_data.scale_y};
	assign body_we    = (cmd.op == OP_LOAD) && cmd.load_we;
	assign body_wdata = {in_data.pos_x, in_data.pos_y, in_data.vel_x, in_data.vel_y,
		rad_sum[31:2]};

	cbps_ram #(.WIDTH(BODY_W), .DEPTH(MAX_BODIES)) u_body_ram (
		.clk  (clk),
		.we   (body_we),
		.waddr(cmd.addr),
		.wdata(body_wdata),
		.raddr(cmd.addr),
		.rdata(body_rdata)
	);

	assign force_we    = (cmd.op == OP_APPLY) || (cmd.op == OP_ROW_WB);
	assign force_waddr = cmd.addr;
	always_comb begin
		if (cmd.op == OP_APPLY)
			force_wdata = {sat32(ext32(fb_y_q) - ext32(fy_q)),
				sat32(ext32(fb_x_q) - ext32(fx_q))};
		else
			force_wdata = {acc_y_q, acc_x_q};
	end

	cbps_ram #(.WIDTH(FORCE_W), .DEPTH(MAX_BODIES)) u_force_ram (
		.clk  (clk),
		.we   (force_we),
		.waddr(force_waddr),
		.wdata(force_wdata),
		.raddr(cmd.addr),
		.rdata(force_rdata)
	);

	assign rd_px = body_rdata[BODY_W-1 -: 32];
	assign rd_py = body_rdata[BODY_W-33 -: 32];
	assign rd_vx = body_rdata[BODY_W-65 -: 32];
	assign rd_vy = body_rdata[BODY_W-97 -: 32];
	assign rd_r  = body_rdata[RAD_W-1:0];
	// forces not yet written in this step read as zero
	assign rd_fx = fvalid_q[cmd.addr] ? force_rdata[31:0] : 32'sd0;
	assign rd_fy = fvalid_q[cmd.addr] ? force_rdata[63:32] : 32'sd0;

	assign dx_d = $signed({px_b_q[31], px_b_q}) - $signed({px_a_q[31], px_a_q});
	assign dy_d = $signed({py_b_q[31], py_b_q}) - $signed({py_a_q[31], py_a_q});

	// one shared multiplier, product registered
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_SQ_X: begin
				ma = dx_q;
				mb = dx_q;
			end
			OP_SQ_Y: begin
				ma = dy_q;
				mb = dy_q;
			end
			OP_MUL_X: begin
				ma = ov_q;
				mb = {{15{ux_q[17]}}, ux_q};
			end
			OP_MUL_Y: begin
				ma = ov_q;
				mb = {{15{uy_q[17]}}, uy_q};
			end
			OP_DRAG_X: begin
				ma = $signed({2'b0, drag});
				mb = {vx_a_q[31], vx_a_q};
			end
			OP_DRAG_Y: begin
				ma = $signed({2'b0, drag});
				mb = {vy_a_q[31], vy_a_q};
			end
			OP_VEL_X: begin
				ma = $signed({2'b0, ds_q});
				mb = {acc_x_q[31], acc_x_q};
			end
			OP_VEL_Y: begin
				ma = $signed({2'b0, ds_q});
				mb = {acc_y_q[31], acc_y_q};
			end
			OP_POS_X: begin
				ma = $signed({2'b0, ds_q});
				mb = {nvx_q[31], nvx_q};
			end
			OP_POS_Y: begin
				ma = $signed({2'b0, ds_q});
				mb = {nvy_q[31], nvy_q};
			end
			default: ;
		endcase
	end

	assign fcalc = trunc16(mul1000(p_q));
	assign ptr   = trunc16(p_q);

	assign rsum = root_q + bit_q;
	assign rsx  = {remx_q[31:0], (it_q == '0) ? adx_q[0] : 1'b0};
	assign rsy  = {remy_q[31:0], (it_q == '0) ? ady_q[0] : 1'b0};
	assign gex  = rsx >= {1'b0, len_q};
	assign gey  = rsy >= {1'b0, len_q};

	// wall overshoot, pushed back toward the inside
	always_comb begin
		r36  = $signed({6'b0, r_a_q});
		px36 = {{4{px_a_q[31]}}, px_a_q};
		py36 = {{4{py_a_q[31]}}, py_a_q};
		ia36 = $signed({5'b0, inv_aspect});
		left  = px36 - r36;
		right = px36 + r36;
		top   = py36 + r36;
		bot   = py36 - r36;
		wx = '0;
		wy = '0;
		if (left < -36'sd65536)
			wx = wx + (-36'sd65536 - left);
		if (top > ia36)
			wy = wy - (top - ia36);
		if (right > 36'sd65536)
			wx = wx - (right - 36'sd65536);
		if (bot < -ia36)
			wy = wy + (-ia36 - bot);
		wx48 = {{12{wx[35]}}, wx};
		wy48 = {{12{wy[35]}}, wy};
	end

	always_ff @(posedge clk) begin
		p_q <= ma * mb;
		case (cmd.op)
			OP_START: ds_q <= in_data.time_step;
			OP_ROW_LD, OP_MV_LD: begin
				px_a_q  <= rd_px;
				py_a_q  <= rd_py;
				vx_a_q  <= rd_vx;
				vy_a_q  <= rd_vy;
				r_a_q   <= rd_r;
				acc_x_q <= rd_fx;
				acc_y_q <= rd_fy;
			end
			OP_PAIR_LD: begin
				px_b_q <= rd_px;
				py_b_q <= rd_py;
				r_b_q  <= rd_r;
				fb_x_q <= rd_fx;
				fb_y_q <= rd_fy;
			end
			OP_DIFF: begin
				dx_q  <= dx_d;
				dy_q  <= dy_d;
				adx_q <= dx_d[32] ? 33'(-dx_d) : 33'(dx_d);
				ady_q <= dy_d[32] ? 33'(-dy_d) : 33'(dy_d);
				s_q   <= {1'b0, r_a_q} + {1'b0, r_b_q};
			end
			OP_SQ_Y: sq_q <= p_q[61:0];
			OP_SQ_SUM: begin
				rad_q  <= {2'b0, sq_q} + {2'b0, p_q[61:0]};
				root_q <= '0;
				bit_q  <= 64'd1 << 62;
				it_q   <= '0;
			end
			OP_SQRT: begin
				if (rad_q >= rsum) begin
					rad_q  <= rad_q - rsum;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				it_q  <= it_q + 5'd1;
			end
			OP_LEN: begin
				len_q  <= root_q[31:0];
				ov_q   <= $signed({1'b0, root_q[31:0]}) - $signed({2'b0, s_q});
				remx_q <= {1'b0, adx_q[32:1]};
				remy_q <= {1'b0, ady_q[32:1]};
				it_q   <= '0;
			end
			OP_DIV: begin
				remx_q <= gex ? rsx - {1'b0, len_q} : rsx;
				remy_q <= gey ? rsy - {1'b0, len_q} : rsy;
				qx_q   <= {qx_q[15:0], gex};
				qy_q   <= {qy_q[15:0], gey};
				it_q   <= it_q + 5'd1;
			end
			OP_UNIT: begin
				ux_q <= dx_q[32] ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
				uy_q <= dy_q[32] ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});
			end
			OP_MUL_Y: fx_q <= sat32(fcalc);
			OP_FY:    fy_q <= sat32(fcalc);
			OP_APPLY: begin
				acc_x_q <= sat32(ext32(acc_x_q) + ext32(fx_q));
				acc_y_q <= sat32(ext32(acc_y_q) + ext32(fy_q));
			end
			OP_WALL: begin
				wx_q <= (wx48 <<< 10) - (wx48 <<< 4) - (wx48 <<< 3);
				wy_q <= (wy48 <<< 10) - (wy48 <<< 4) - (wy48 <<< 3);
			end
			OP_DRAG_X: begin
				acc_x_q <= sat32(ext32(acc_x_q) + {{18{wx_q[47]}}, wx_q});
				acc_y_q <= sat32(ext32(acc_y_q) + {{18{wy_q[47]}}, wy_q});
			end
			OP_DRAG_Y: acc_x_q <= sat32(ext32(acc_x_q) - ptr);
			OP_VEL_X:  acc_y_q <= sat32(ext32(acc_y_q) - ptr);
			OP_VEL_Y:  nvx_q   <= sat32(ext32(vx_a_q) + ptr);
			OP_POS_X:  nvy_q   <= sat32(ext32(vy_a_q) + ptr);
			OP_POS_Y:  npx_q   <= sat32(ext32(px_a_q) + ptr);
			OP_POS_FIN: npy_q  <= sat32(ext32(py_a_q) + ptr);
			OP_EMIT: begin
				if (out_free) begin
					out_q.body_index <= 6'(cmd.addr);
					out_q.new_pos_x  <= npx_q;
					out_q.new_pos_y  <= npy_q;
					out_q.new_vel_x  <= nvx_q;
					out_q.new_vel_y  <= nvy_q;
					out_q.last_body  <= cmd.last;
				end
			end
			default: ;
		endcase
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			fvalid_q    <= '0;
		end else begin
			if (cmd.op == OP_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cmd.op == OP_START)
				fvalid_q <= '0;
			else if (force_we)
				fvalid_q[force_waddr] <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign status.far       = (adx_q >= {2'b0, s_q}) || (ady_q >= {2'b0, s_q});
	assign status.len_bad   = (root_q == 64'd0) || (root_q >= {33'b0, s_q});
	assign status.sqrt_last = (it_q == 5'd31);
	assign status.div_last  = (it_q == 5'd16);
	assign status.out_free  = out_free;
endmodule
`default_nettype wire

@@ design/circle_body_physics_step_unit.sv @@
// Top level: configuration registers, controller and datapath of the physics step unit.
//
//  channel | signals                                   | word
//  --------+-------------------------------------------+-------------------------
//  in      | in_valid, in_ready, in_data               | load body / run step
//  out     | out_valid, out_ready, out_data            | one body's new state
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | drag, inverse aspect
//
// A load adds a body unless the store is full, and loads go back to back. A step walks
// each body row; per pair it skips bodies apart on an axis, stops after the square root
// when close but not touching or coincident, and on contact runs the square root, then
// the divider; then each body gets walls, drag and the Euler update. Output words leave
// through a register; a stalled out_ready holds the sequencer in its emit state. Input is
// taken only between steps. Reset clears control and drag and sets the aspect to 65536.
`default_nettype none
module circle_body_physics_step_unit import cbps_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_word_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_word_t                 out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);
	logic [CFG_W-1:0] drag_q, aspect_q;
	ctl_cmd_t         cmd;
	dp_status_t       status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_q   <= '0;
			aspect_q <= ASPECT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DRAG:   drag_q   <= cfg_data;
				REG_ASPECT: aspect_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cbps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_action(in_data.action),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	cbps_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.drag      (drag_q),
		.inv_aspect(aspect_q),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.status    (status)
	);
endmodule
`default_nettype wire

@@ bench/cbps_checker.sv @@
// Checker for the physics step unit: predicts each body's new state and compares output words.
`timescale 1ns / 100ps
module cbps_checker import cbps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_word_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_word_t            out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending
);

	localparam longint PEN = 1000;
	localparam longint ONE = 65536;

	longint drag_q, aspect_q;
	int held;
	longint bpx[MAX_BODIES], bpy[MAX_BODIES], bvx[MAX_BODIES], bvy[MAX_BODIES];
	longint brad[MAX_BODIES];
	out_word_t body_results[$];

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint root_floor(longint n);
		longint r, b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	task automatic run_step(longint dt);
		longint fx[MAX_BODIES], fy[MAX_BODIES];
		longint dx, dy, s, len, ov, ux, uy, px_f, py_f, wx, wy, vx, vy, nx, ny;
		out_word_t w;
		for (int i = 0; i < held; i++) begin
			fx[i] = 0;
			fy[i] = 0;
		end
		for (int i = 0; i < held; i++)
			for (int j = i + 1; j < held; j++) begin
				dx = bpx[j] - bpx[i];
				dy = bpy[j] - bpy[i];
				s = brad[i] + brad[j];
				if (mag(dx) >= s || mag(dy) >= s) continue;
				len = root_floor(dx * dx + dy * dy);
				if (len == 0 || len >= s) continue;
				ov = len - s;
				ux = dx * ONE / len;
				uy = dy * ONE / len;
				px_f = clamp32(ov * PEN * ux / ONE);
				py_f = clamp32(ov * PEN * uy / ONE);
				fx[i] = clamp32(fx[i] + px_f);
				fy[i] = clamp32(fy[i] + py_f);
				fx[j] = clamp32(fx[j] - px_f);
				fy[j] = clamp32(fy[j] - py_f);
			end
		for (int i = 0; i < held; i++) begin
			wx = 0;
			wy = 0;
			if (bpx[i] - brad[i] < -ONE) wx += -ONE - (bpx[i] - brad[i]);
			if (bpy[i] + brad[i] > aspect_q) wy -= bpy[i] + brad[i] - aspect_q;
			if (bpx[i] + brad[i] > ONE) wx -= bpx[i] + brad[i] - ONE;
			if (bpy[i] - brad[i] < -aspect_q) wy += -aspect_q - (bpy[i] - brad[i]);
			fx[i] = clamp32(fx[i] + wx * PEN);
			fy[i] = clamp32(fy[i] + wy * PEN);
		end
		for (int i = 0; i < held; i++) begin
			fx[i] = clamp32(fx[i] - drag_q * bvx[i] / ONE);
			fy[i] = clamp32(fy[i] - drag_q * bvy[i] / ONE);
		end
		for (int i = 0; i < held; i++) begin
			vx = clamp32(bvx[i] + dt * fx[i] / ONE);
			vy = clamp32(bvy[i] + dt * fy[i] / ONE);
			nx = clamp32(bpx[i] + dt * vx / ONE);
			ny = clamp32(bpy[i] + dt * vy / ONE);
			w.body_index = i[5:0];
			w.new_pos_x = nx[31:0];
			w.new_pos_y = ny[31:0];
			w.new_vel_x = vx[31:0];
			w.new_vel_y = vy[31:0];
			w.last_body = (i + 1 == held);
			body_results = {body_results, w};
		end
		held = 0;
	endtask

	assign pending = body_results.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_q <= 0;
			aspect_q <= 65536;
			held = 0;
			fail_count = 0;
			body_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DRAG) drag_q <= longint'(cfg_data);
				else if (cfg_index == REG_ASPECT) aspect_q <= longint'(cfg_data);
			end
			if (in_valid && in_ready) begin
				if (!in_data.action) begin
					if (held < MAX_BODIES) begin
						bpx[held] = longint'(in_data.pos_x);
						bpy[held] = longint'(in_data.pos_y);
						bvx[held] = longint'(in_data.vel_x);
						bvy[held] = longint'(in_data.vel_y);
						brad[held] = (longint'(in_data.scale_x) + longint'(in_data.scale_y)) >>> 2;
						held++;
					end
				end else begin
					run_step(longint'(in_data.time_step));
				end
			end
			if (out_valid && out_ready) begin
				if (body_results.size() == 0) begin
					$error("unexpected word: body_index %0d", out_data.body_index);
					fail_count++;
				end else begin
					out_word_t e;
					e = body_results.pop_front();
					if (e.body_index !== out_data.body_index) begin
						$error("body_index exp %0d got %0d", e.body_index, out_data.body_index);
						fail_count++;
					end
					if (e.new_pos_x !== out_data.new_pos_x) begin
						$error("new_pos_x exp %0d got %0d", e.new_pos_x, out_data.new_pos_x);
						fail_count++;
					end
					if (e.new_pos_y !== out_data.new_pos_y) begin
						$error("new_pos_y exp %0d got %0d", e.new_pos_y, out_data.new_pos_y);
						fail_count++;
					end
					if (e.new_vel_x !== out_data.new_vel_x) begin
						$error("new_vel_x exp %0d got %0d", e.new_vel_x, out_data.new_vel_x);
						fail_count++;
					end
					if (e.new_vel_y !== out_data.new_vel_y) begin
						$error("new_vel_y exp %0d got %0d", e.new_vel_y, out_data.new_vel_y);
						fail_count++;
					end
					if (e.last_body !== out_data.last_body) begin
						$error("last_body exp %0d got %0d", e.last_body, out_data.last_body);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

@@ bench/tb_top.sv @@
// Stimulus and verdict for the circle body physics step unit.
`timescale 1ns / 100ps
module tb_top;
	import cbps_pkg::*;

	localparam int IN_W = $bits(in_word_t);

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready;
	in_word_t in_data = '0;
	logic out_valid, out_ready = 0;
	out_word_t out_data;
	logic cfg_valid = 0, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_DRAG;
	logic [CFG_W-1:0] cfg_data = '0;
	int fail_count, pending;
	int send_idle = 0, recv_idle = 0;
	bit long_hold = 0;

	always #4 clk = ~clk;

	circle_body_physics_step_unit dut (.*);

	cbps_checker chk (.*);

	// receiver: random stall, plus one long hold-off on request
	always @(posedge clk) begin
		if (long_hold) out_ready <= 0;
		else out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// valid stays up between back-to-back words; drop it only while idling
	task automatic send_word(in_word_t w);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_regs(logic [CFG_W-1:0] drag_val, logic [CFG_W-1:0] aspect_val);
		cfg_valid <= 1;
		cfg_index <= REG_DRAG;
		cfg_data <= drag_val;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_ASPECT;
		cfg_data <= aspect_val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic drain;
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rnd_coord(int mode);
		case (mode)
			0: return $signed($urandom_range(0, 196608)) - 98304;
			1: return $signed($urandom_range(0, 16384)) - 8192;
			default: return $urandom;
		endcase
	endfunction

	task automatic load_body(int mode);
		in_word_t w;
		w.action = 0;
		w.pos_x = rnd_coord(mode);
		w.pos_y = rnd_coord(mode);
		w.vel_x = (mode == 2) ? $urandom : $signed($urandom_range(0, 262144)) - 131072;
		w.vel_y = (mode == 2) ? $urandom : $signed($urandom_range(0, 262144)) - 131072;
		w.scale_x = (mode == 2) ? 31'($urandom) : 31'($urandom_range(0, 32768));
		w.scale_y = (mode == 2) ? 31'($urandom) : 31'($urandom_range(0, 32768));
		w.time_step = 31'($urandom);
		send_word(w);
	endtask

	task automatic step_all(logic [30:0] dt);
		in_word_t w;
		w = in_word_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom}));
		w.action = 1;
		w.time_step = dt;
		send_word(w);
	endtask

	task automatic random_phase(int items);
		int sent, n, mode;
		sent = 0;
		while (sent < items) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(16, 18) : $urandom_range(0, 5);
			mode = $urandom_range(9) < 7 ? $urandom_range(0, 1) : 2;
			for (int k = 0; k < n; k++) load_body(mode);
			step_all(($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 8192)));
			sent += n + 1;
		end
	endtask

	initial begin
		in_word_t w;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// empty step, then extremes
		step_all(31'h7fffffff);
		w = '0;
		w.pos_x = 32'sh7fffffff; w.pos_y = 32'sh80000000;
		w.vel_x = 32'sh80000000; w.vel_y = 32'sh7fffffff;
		w.scale_x = 31'h7fffffff; w.scale_y = 31'h7fffffff;
		send_word(w);
		send_word(w);
		w = '0; // coincident centres
		w.scale_x = 31'd65536; w.scale_y = 31'd65536;
		send_word(w);
		send_word(w);
		step_all(31'h7fffffff);
		drain();
		write_regs(31'h7fffffff, 31'd0);
		w = '0;
		w.pos_x = 32'sh00008000; w.pos_y = -32'sh00004000;
		w.vel_x = 32'sh00010000; w.vel_y = -32'sh00020000;
		w.scale_x = 31'd40000; w.scale_y = 31'd40000;
		send_word(w);
		w.pos_x = 32'sh00009000;
		send_word(w);
		step_all(31'd655);
		// overfill store
		for (int k = 0; k < 17; k++) load_body(1);
		step_all(31'd3000);
		drain();
		write_regs(31'd0, 31'h7fffffff);
		send_idle = 24; recv_idle = 86;
		random_phase(110);
		drain();
		write_regs(31'd6554, 31'd43690);
		send_idle = 86; recv_idle = 24;
		random_phase(110);
		drain();
		write_regs(31'($urandom), 31'd65536);
		send_idle = 0; recv_idle = 0;
		// long receiver hold while the sender keeps offering
		long_hold = 1;
		fork
			begin
				repeat (2000) @(posedge clk);
				long_hold = 0;
			end
			begin
				for (int k = 0; k < 4; k++) load_body(0);
				step_all(31'd1000);
				for (int k = 0; k < 3; k++) load_body(0);
				step_all(31'd1000);
			end
		join
		drain();
		random_phase(100);
		drain();
		if (fail_count == 0)
			$display("[circle_body_physics_step_unit] OK");
		else
			$display("[circle_body_physics_step_unit] ERROR");
		$finish;
	end

	initial begin
		#40ms;
		$display("[circle_body_physics_step_unit] ERROR");
		$finish;
	end

endmodule
